// ===== design/hppe_pkg.sv =====
package hppe_pkg;

   localparam int PAGE_DEPTH = 8192;
   localparam int ADDR_W     = 13;
   localparam int BYTE_W     = 8;

   localparam logic [8:0] MAX_X        = 9'd279;
   localparam logic [7:0] MAX_Y        = 8'd191;
   localparam logic [5:0] MAX_COL      = 6'd39;
   localparam logic [5:0] MAX_SEAM_COL = 6'd38;

   // reciprocal of seven, scaled by 2^11, exact for columns up to 279
   localparam logic [8:0] RECIP_SEVEN = 9'd293;
   localparam int         RECIP_SHIFT = 11;

   localparam logic [7:0] PALETTE_BIT = 8'h80;
   localparam logic [7:0] PIXEL_BITS  = 8'h7F;

   // opcodes
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_PLOT  = 3'd2;
   localparam logic [2:0] OP_QUERY = 3'd3;
   localparam logic [2:0] OP_PAL   = 3'd4;
   localparam logic [2:0] OP_SEAM  = 3'd5;

   // colours
   localparam logic [2:0] COL_BLACK  = 3'd0;
   localparam logic [2:0] COL_WHITE  = 3'd1;
   localparam logic [2:0] COL_VIOLET = 3'd2;
   localparam logic [2:0] COL_GREEN  = 3'd3;
   localparam logic [2:0] COL_BLUE   = 3'd4;
   localparam logic [2:0] COL_ORANGE = 3'd5;

   // palette modes, anything else toggles
   localparam logic [1:0] PM_CLEAR = 2'd0;
   localparam logic [1:0] PM_SET   = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SECOND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]        op;
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        bit_idx;
      logic              even;
      logic [2:0]        color;
      logic [1:0]        pmode;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic              wr;
      logic [BYTE_W-1:0] wdata;
      logic              done;
      logic [ADDR_W-1:0] offset;
      logic              lit;
      logic [2:0]        pcolor;
      logic              seam;
      logic [BYTE_W-1:0] bval;
   } res_type;

endpackage

// ===== design/hppe_ram.sv =====
module hppe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/hppe_decode.sv =====
module hppe_decode (
   input  logic             clock,
   input  logic             load,
   input  logic [2:0]       opcode,
   input  logic [8:0]       x_coord,
   input  logic [7:0]       y_coord,
   input  logic [2:0]       color,
   input  logic [5:0]       byte_column,
   input  logic [1:0]       palette_mode,
   input  logic [7:0]       load_data,
   output hppe_pkg::cmd_type cmd
);

   hppe_pkg::cmd_type cmd_in;
   hppe_pkg::cmd_type cmd_ff;

   logic        y_ok;
   logic        col_ok;
   logic        x_ok;
   logic        chroma;
   logic        want_odd;
   logic [8:0]  sx;
   logic [17:0] prod;
   logic [5:0]  quot;
   logic [8:0]  rem;
   logic [5:0]  col_sel;
   logic [hppe_pkg::ADDR_W-1:0] base;

   always_comb begin
      y_ok   = (y_coord <= hppe_pkg::MAX_Y);
      col_ok = (byte_column <= hppe_pkg::MAX_COL);
      x_ok   = (x_coord <= hppe_pkg::MAX_X);

      // chromatic plots snap to the column parity of their colour
      chroma   = (opcode == hppe_pkg::OP_PLOT) && (color >= hppe_pkg::COL_VIOLET)
                 && (color <= hppe_pkg::COL_ORANGE);
      want_odd = (color == hppe_pkg::COL_GREEN) || (color == hppe_pkg::COL_ORANGE);
      sx = x_coord;
      if (chroma && (x_coord[0] != want_odd)) begin
         sx = (x_coord == 9'd0) ? 9'd1 : x_coord - 9'd1;
      end

      // divide by seven through the reciprocal
      prod    = 18'(sx) * 18'(hppe_pkg::RECIP_SEVEN);
      quot    = prod[hppe_pkg::RECIP_SHIFT +: 6];
      rem     = sx - 9'(quot) * 9'd7;
      col_sel = ((opcode == hppe_pkg::OP_PLOT) || (opcode == hppe_pkg::OP_QUERY)) ?
                quot : byte_column;

      // interleaved row base: 0x28 per third, 0x80 per block, 0x400 per line
      base = {y_coord[2:0], y_coord[5:3], 7'd0}
             + 13'({y_coord[7:6], 5'd0}) + 13'({y_coord[7:6], 3'd0});

      cmd_in.op      = opcode;
      cmd_in.addr    = base + 13'(col_sel);
      cmd_in.bit_idx = rem[2:0];
      cmd_in.even    = ~sx[0];
      cmd_in.color   = color;
      cmd_in.pmode   = palette_mode;
      cmd_in.data    = load_data;
      case (opcode)
         hppe_pkg::OP_LOAD, hppe_pkg::OP_READ, hppe_pkg::OP_PAL:
            cmd_in.ok = y_ok && col_ok;
         hppe_pkg::OP_PLOT:
            cmd_in.ok = y_ok && x_ok && (color <= hppe_pkg::COL_ORANGE);
         hppe_pkg::OP_QUERY:
            cmd_in.ok = y_ok && x_ok;
         hppe_pkg::OP_SEAM:
            cmd_in.ok = y_ok && (byte_column <= hppe_pkg::MAX_SEAM_COL);
         default:
            cmd_in.ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

// ===== design/hppe_alu.sv =====
module hppe_alu (
   input  hppe_pkg::cmd_type cmd,
   input  logic [7:0]        rd_byte,
   input  logic [7:0]        left_byte,
   output hppe_pkg::res_type res
);

   logic [7:0] mask;
   logic [7:0] nb;
   logic [8:0] win;
   logic       lit;

   always_comb begin
      mask = 8'd1 << cmd.bit_idx;
      // window: bit-1 at [0], bit at [1], bit+1 at [2]
      win  = {rd_byte, 1'b0} >> cmd.bit_idx;
      lit  = win[1];
      nb   = rd_byte;

      res = '0;
      case (cmd.op)
         hppe_pkg::OP_LOAD: begin
            res.wr    = cmd.ok;
            res.wdata = cmd.data;
            res.done  = cmd.ok;
         end
         hppe_pkg::OP_READ: begin
            res.done = cmd.ok;
            res.bval = cmd.ok ? rd_byte : 8'd0;
         end
         hppe_pkg::OP_PLOT: begin
            case (cmd.color)
               hppe_pkg::COL_BLACK:  nb = rd_byte & ~mask;
               hppe_pkg::COL_WHITE:  nb = rd_byte | mask;
               hppe_pkg::COL_BLUE,
               hppe_pkg::COL_ORANGE: nb = rd_byte | hppe_pkg::PALETTE_BIT | mask;
               default:              nb = (rd_byte & hppe_pkg::PIXEL_BITS) | mask;
            endcase
            res.wr    = cmd.ok && (nb != rd_byte);
            res.wdata = nb;
            res.done  = res.wr;
         end
         hppe_pkg::OP_QUERY: begin
            res.done = cmd.ok;
            res.lit  = cmd.ok && lit;
            if (cmd.ok && lit) begin
               if ((cmd.bit_idx != 3'd0) && (cmd.bit_idx < 3'd6) && win[0] && win[2]) begin
                  res.pcolor = hppe_pkg::COL_WHITE;
               end else if (rd_byte[7]) begin
                  res.pcolor = cmd.even ? hppe_pkg::COL_BLUE : hppe_pkg::COL_ORANGE;
               end else begin
                  res.pcolor = cmd.even ? hppe_pkg::COL_VIOLET : hppe_pkg::COL_GREEN;
               end
            end
         end
         hppe_pkg::OP_PAL: begin
            case (cmd.pmode)
               hppe_pkg::PM_CLEAR: nb = rd_byte & hppe_pkg::PIXEL_BITS;
               hppe_pkg::PM_SET:   nb = rd_byte | hppe_pkg::PALETTE_BIT;
               default:            nb = rd_byte ^ hppe_pkg::PALETTE_BIT;
            endcase
            res.wr    = cmd.ok && (nb != rd_byte);
            res.wdata = nb;
            res.done  = res.wr;
         end
         hppe_pkg::OP_SEAM: begin
            res.done = cmd.ok;
            res.seam = cmd.ok && ((left_byte & hppe_pkg::PIXEL_BITS) != 8'd0)
                       && ((rd_byte & hppe_pkg::PIXEL_BITS) != 8'd0)
                       && (left_byte[7] != rd_byte[7]);
         end
         default: begin
            res = '0;
         end
      endcase
      res.offset = res.done ? cmd.addr : '0;
   end

endmodule

// ===== design/hires_pixel_plot_engine_top.sv =====
// hi-res page engine: holds one 8 KB interleaved page (280 x 192 pixels, seven per byte
// plus a palette bit) in a single-port synchronous ram and runs one opcode per word: load
// or read a byte, plot, query a pixel, change a palette bit, or check two neighbouring
// bytes for a palette seam. every request word gives exactly one response word. a word
// goes through a ram read state and a finish state that writes back and can take the next
// word; a seam check adds a second read state, since both bytes go through the one ram
// port. from idle the word is first accepted in the idle state. the page is not cleared
// after reset: bytes never loaded read as undefined
module hires_pixel_plot_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [8:0]  req_x_coord,
   input  logic [7:0]  req_y_coord,
   input  logic [2:0]  req_color,
   input  logic [5:0]  req_byte_column,
   input  logic [1:0]  req_palette_mode,
   input  logic [7:0]  req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_done_res,
   output logic [12:0] rsp_offset,
   output logic        rsp_pixel_lit,
   output logic [2:0]  rsp_pixel_color,
   output logic        rsp_seam_found,
   output logic [7:0]  rsp_byte_value
);

   hppe_pkg::state_type state_ff;
   hppe_pkg::state_type state_in;

   hppe_pkg::cmd_type cmd;
   hppe_pkg::res_type res;

   // ram port
   logic                          ram_en;
   logic                          ram_we;
   logic [hppe_pkg::ADDR_W-1:0]   ram_addr;
   logic [hppe_pkg::BYTE_W-1:0]   ram_rdata;

   logic       out_free;
   logic       cmd_load;
   logic       left_load;
   logic       rsp_load;
   logic [7:0] left_ff;

   // response holding register
   logic        rsp_valid_ff;
   logic        rsp_done_ff;
   logic [12:0] rsp_offset_ff;
   logic        rsp_lit_ff;
   logic [2:0]  rsp_pcolor_ff;
   logic        rsp_seam_ff;
   logic [7:0]  rsp_bval_ff;

   // the response register may drain in the same cycle it is refilled
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // command decode: address, bit position and range checks, registered on accept
   hppe_decode u_decode (
      .clock        (clock),
      .load         (cmd_load),
      .opcode       (req_opcode),
      .x_coord      (req_x_coord),
      .y_coord      (req_y_coord),
      .color        (req_color),
      .byte_column  (req_byte_column),
      .palette_mode (req_palette_mode),
      .load_data    (req_load_data),
      .cmd          (cmd)
   );

   // page store
   hppe_ram #(
      .WIDTH (hppe_pkg::BYTE_W),
      .DEPTH (hppe_pkg::PAGE_DEPTH)
   ) u_page (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (res.wdata),
      .rdata (ram_rdata)
   );

   // modify stage: works on the byte read back, left byte held for the seam check
   hppe_alu u_alu (
      .cmd       (cmd),
      .rd_byte   (ram_rdata),
      .left_byte (left_ff),
      .res       (res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hppe_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = hppe_pkg::ST_LOOKUP;
            end
         end
         hppe_pkg::ST_LOOKUP: begin
            state_in = (cmd.op == hppe_pkg::OP_SEAM) ? hppe_pkg::ST_SECOND :
                       hppe_pkg::ST_FINISH;
         end
         hppe_pkg::ST_SECOND: begin
            state_in = hppe_pkg::ST_FINISH;
         end
         hppe_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = req_valid ? hppe_pkg::ST_LOOKUP : hppe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hppe_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = cmd.addr;
      left_load = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         hppe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         hppe_pkg::ST_LOOKUP: begin
            ram_en = 1'b1;
         end
         hppe_pkg::ST_SECOND: begin
            // left byte is on the read port now, fetch the right one
            ram_en    = 1'b1;
            ram_addr  = cmd.addr + 13'd1;
            left_load = 1'b1;
         end
         hppe_pkg::ST_FINISH: begin
            // write-back lands before the next word's read cycle, so no hazard
            req_ready = out_free;
            rsp_load  = out_free;
            ram_en    = out_free & res.wr;
            ram_we    = out_free & res.wr;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd_load = req_valid & req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hppe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (left_load) begin
         left_ff <= ram_rdata;
      end
      if (rsp_load) begin
         rsp_done_ff   <= res.done;
         rsp_offset_ff <= res.offset;
         rsp_lit_ff    <= res.lit;
         rsp_pcolor_ff <= res.pcolor;
         rsp_seam_ff   <= res.seam;
         rsp_bval_ff   <= res.bval;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_pixel_lit   = rsp_lit_ff;
   assign rsp_pixel_color = rsp_pcolor_ff;
   assign rsp_seam_found  = rsp_seam_ff;
   assign rsp_byte_value  = rsp_bval_ff;

endmodule

// ===== tb/page_op_checker.sv =====
module page_op_checker
   import hppe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [8:0]  req_x_coord,
   input  logic [7:0]  req_y_coord,
   input  logic [2:0]  req_color,
   input  logic [5:0]  req_byte_column,
   input  logic [1:0]  req_palette_mode,
   input  logic [7:0]  req_load_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_done_res,
   input  logic [12:0] rsp_offset,
   input  logic        rsp_pixel_lit,
   input  logic [2:0]  rsp_pixel_color,
   input  logic        rsp_seam_found,
   input  logic [7:0]  rsp_byte_value,
   output int          mismatch_count,
   output int          words_in_flight
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        done;
      logic [12:0] offset;
      logic        lit;
      logic [2:0]  pcolor;
      logic        seam;
      logic [7:0]  bval;
   } page_outcome_t;

   logic [7:0]    page_shadow [PAGE_DEPTH];
   page_outcome_t outcome_q [$];
   int            mismatches = 0;

   assign mismatch_count = mismatches;

   // interleaved row start: 64-line group, 8-line block, line within block
   function automatic logic [12:0] row_start(input logic [7:0] y);
      int unsigned base;
      base = (y / 64) * 'h28 + ((y % 64) / 8) * 'h80 + (y % 8) * 'h400;
      return base[12:0];
   endfunction

   function automatic page_outcome_t run_page_op(
      input logic [2:0] op,
      input logic [8:0] x,
      input logic [7:0] y,
      input logic [2:0] color,
      input logic [5:0] col,
      input logic [1:0] pmode,
      input logic [7:0] data
   );
      page_outcome_t r;
      logic [12:0]   a;
      logic [8:0]    sx;
      logic [2:0]    bit_no;
      logic [7:0]    cur, upd, right;
      logic          y_ok;
      r    = '0;
      y_ok = (y <= MAX_Y);
      case (op)
         OP_LOAD, OP_READ: begin
            if (y_ok && col <= MAX_COL) begin
               a        = row_start(y) + 13'(col);
               r.done   = 1'b1;
               r.offset = a;
               if (op == OP_LOAD) page_shadow[a] = data;
               else r.bval = page_shadow[a];
            end
         end
         OP_PLOT: begin
            if (y_ok && x <= MAX_X && color <= COL_ORANGE) begin
               sx = x;
               // chromatic colours snap: violet and blue even, green and orange odd
               if (color >= COL_VIOLET) begin
                  if (sx[0] != (color == COL_GREEN || color == COL_ORANGE))
                     sx = (sx == 9'd0) ? 9'd1 : sx - 9'd1;
               end
               a   = row_start(y) + 13'(sx / 7);
               cur = page_shadow[a];
               upd = cur;
               if (color == COL_BLACK) begin
                  upd[sx % 7] = 1'b0;
               end else begin
                  if (color == COL_BLUE || color == COL_ORANGE) upd = upd | PALETTE_BIT;
                  else if (color != COL_WHITE) upd = upd & PIXEL_BITS;
                  upd[sx % 7] = 1'b1;
               end
               if (upd != cur) begin
                  page_shadow[a] = upd;
                  r.done         = 1'b1;
                  r.offset       = a;
               end
            end
         end
         OP_QUERY: begin
            if (y_ok && x <= MAX_X) begin
               a        = row_start(y) + 13'(x / 7);
               bit_no   = 3'(x % 7);
               cur      = page_shadow[a];
               r.done   = 1'b1;
               r.offset = a;
               r.lit    = cur[bit_no];
               if (r.lit) begin
                  if (bit_no >= 3'd1 && bit_no <= 3'd5 && cur[bit_no - 3'd1] && cur[bit_no + 3'd1])
                     r.pcolor = COL_WHITE;
                  else if (cur[7])
                     r.pcolor = x[0] ? COL_ORANGE : COL_BLUE;
                  else
                     r.pcolor = x[0] ? COL_GREEN : COL_VIOLET;
               end
            end
         end
         OP_PAL: begin
            if (y_ok && col <= MAX_COL) begin
               a   = row_start(y) + 13'(col);
               cur = page_shadow[a];
               case (pmode)
                  PM_CLEAR: upd = cur & PIXEL_BITS;
                  PM_SET:   upd = cur | PALETTE_BIT;
                  default:  upd = cur ^ PALETTE_BIT;
               endcase
               if (upd != cur) begin
                  page_shadow[a] = upd;
                  r.done         = 1'b1;
                  r.offset       = a;
               end
            end
         end
         OP_SEAM: begin
            if (y_ok && col <= MAX_SEAM_COL) begin
               a        = row_start(y) + 13'(col);
               cur      = page_shadow[a];
               right    = page_shadow[a + 13'd1];
               r.done   = 1'b1;
               r.offset = a;
               r.seam   = (|cur[6:0]) && (|right[6:0]) && (cur[7] != right[7]);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [12:0] want, input logic [12:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // response first: a response taken on this edge cannot answer a word accepted on the same edge
   always @(posedge clock) begin
      page_outcome_t want;
      if (reset) begin
         outcome_q.delete();
         words_in_flight <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("response word with no request outstanding");
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               check_field("done_res", 13'(want.done), 13'(rsp_done_res));
               check_field("offset", want.offset, rsp_offset);
               check_field("pixel_lit", 13'(want.lit), 13'(rsp_pixel_lit));
               check_field("pixel_color", 13'(want.pcolor), 13'(rsp_pixel_color));
               check_field("seam_found", 13'(want.seam), 13'(rsp_seam_found));
               check_field("byte_value", 13'(want.bval), 13'(rsp_byte_value));
            end
         end
         if (req_valid && req_ready)
            outcome_q.push_back(run_page_op(req_opcode, req_x_coord, req_y_coord, req_color,
                                            req_byte_column, req_palette_mode, req_load_data));
         words_in_flight <= outcome_q.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import hppe_pkg::*;

   // codes the block treats as no-ops or rejects, plus the two palette toggle codes
   localparam logic [2:0] OP_SPARE_6    = 3'd6;
   localparam logic [2:0] OP_SPARE_7    = 3'd7;
   localparam logic [2:0] COL_SPARE_6   = 3'd6;
   localparam logic [2:0] COL_SPARE_7   = 3'd7;
   localparam logic [1:0] PM_TOGGLE     = 2'd2;
   localparam logic [1:0] PM_TOGGLE_ALT = 2'd3;

   localparam int RANDOM_WORDS = 600;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 16;

   typedef struct {
      logic [2:0] op;
      logic [8:0] x;
      logic [7:0] y;
      logic [2:0] color;
      logic [5:0] col;
      logic [1:0] pmode;
      logic [7:0] data;
   } page_cmd_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [8:0]  req_x_coord;
   logic [7:0]  req_y_coord;
   logic [2:0]  req_color;
   logic [5:0]  req_byte_column;
   logic [1:0]  req_palette_mode;
   logic [7:0]  req_load_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_done_res;
   logic [12:0] rsp_offset;
   logic        rsp_pixel_lit;
   logic [2:0]  rsp_pixel_color;
   logic        rsp_seam_found;
   logic [7:0]  rsp_byte_value;
   int          mismatch_count;
   int          words_in_flight;

   // no idling on either side while set
   bit calm = 1'b0;

   // bytes (row, byte column) the page has been loaded with; no result depends on any other byte
   bit loaded [192][40];

   hires_pixel_plot_engine_top u_dut (.*);

   page_op_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response side back-pressure, ready low about 16 percent of the time unless calm
   always @(posedge clock) begin
      if (calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic page_cmd_t mk(input logic [2:0] op, input logic [8:0] x,
                                    input logic [7:0] y, input logic [2:0] color,
                                    input logic [5:0] col, input logic [1:0] pmode,
                                    input logic [7:0] data);
      page_cmd_t c;
      c.op    = op;
      c.x     = x;
      c.y     = y;
      c.color = color;
      c.col   = col;
      c.pmode = pmode;
      c.data  = data;
      return c;
   endfunction

   // byte contents leaning towards empty, full and palette-only bytes
   function automatic logic [7:0] fill_byte();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h7F;
         3:       return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic page_cmd_t random_cmd();
      page_cmd_t c;
      int        pick, k;
      pick = $urandom_range(99);
      if (pick < 14)      c.op = OP_LOAD;
      else if (pick < 22) c.op = OP_READ;
      else if (pick < 50) c.op = OP_PLOT;
      else if (pick < 70) c.op = OP_QUERY;
      else if (pick < 82) c.op = OP_PAL;
      else if (pick < 97) c.op = OP_SEAM;
      else c.op = 3'($urandom_range(OP_SPARE_7, OP_SPARE_6));

      // rows mostly from a handful at the group edges so bytes get reused
      pick = $urandom_range(99);
      if (pick < 8) begin
         c.y = 8'($urandom_range(255, 192));
      end else if (pick < 65) begin
         k   = $urandom_range(5);
         c.y = 8'((k / 2) * 64 + (k % 2) * 63);
      end else begin
         c.y = 8'($urandom_range(MAX_Y));
      end

      pick = $urandom_range(99);
      if (pick < 6)       c.x = 9'($urandom_range(511, 280));
      else if (pick < 10) c.x = $urandom_range(1) ? MAX_X : 9'd0;
      else c.x = 9'($urandom_range(MAX_X));

      if ($urandom_range(99) < 5) c.color = 3'($urandom_range(COL_SPARE_7, COL_SPARE_6));
      else c.color = 3'($urandom_range(COL_ORANGE, COL_BLACK));

      pick = $urandom_range(99);
      if (c.op == OP_SEAM)
         c.col = (pick < 6) ? 6'($urandom_range(63, 39)) : 6'($urandom_range(MAX_SEAM_COL));
      else
         c.col = (pick < 6) ? 6'($urandom_range(63, 40)) : 6'($urandom_range(MAX_COL));

      c.pmode = 2'($urandom_range(PM_TOGGLE_ALT, PM_CLEAR));
      c.data  = fill_byte();
      return c;
   endfunction

   // one word on the request channel, with a random gap in front of it
   task automatic send_word(input page_cmd_t c);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_opcode       <= c.op;
      req_x_coord      <= c.x;
      req_y_coord      <= c.y;
      req_color        <= c.color;
      req_byte_column  <= c.col;
      req_palette_mode <= c.pmode;
      req_load_data    <= c.data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // loads any byte the word would read that has never been written, then sends the word
   task automatic issue(input page_cmd_t c);
      int need [$];
      if (c.y <= MAX_Y) begin
         case (c.op)
            OP_READ, OP_PAL: begin
               if (c.col <= MAX_COL) need.push_back(c.col);
            end
            OP_SEAM: begin
               if (c.col <= MAX_SEAM_COL) begin
                  need.push_back(c.col);
                  need.push_back(c.col + 1);
               end
            end
            OP_QUERY: begin
               if (c.x <= MAX_X) need.push_back(c.x / 7);
            end
            OP_PLOT: begin
               // a snapped column can land in the byte to the left
               if (c.x <= MAX_X) begin
                  need.push_back(c.x / 7);
                  if (c.x != 9'd0) need.push_back((c.x - 1) / 7);
               end
            end
            default: begin
            end
         endcase
      end
      foreach (need[i]) begin
         if (!loaded[c.y][need[i]]) begin
            send_word(mk(OP_LOAD, 9'd0, c.y, COL_BLACK, 6'(need[i]), PM_CLEAR, fill_byte()));
            loaded[c.y][need[i]] = 1'b1;
         end
      end
      if (c.op == OP_LOAD && c.y <= MAX_Y && c.col <= MAX_COL) loaded[c.y][c.col] = 1'b1;
      send_word(c);
   endtask

   // hold the request side off until every response word is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_LOAD;
      req_x_coord      <= '0;
      req_y_coord      <= '0;
      req_color        <= COL_BLACK;
      req_byte_column  <= '0;
      req_palette_mode <= PM_CLEAR;
      req_load_data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // raw loads at the page corners, plus rejected rows and columns
      issue(mk(OP_LOAD, 9'd0, 8'd0, COL_BLACK, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_LOAD, 9'd0, 8'd0, COL_BLACK, 6'd1, PM_CLEAR, 8'h0E));
      issue(mk(OP_LOAD, 9'd0, 8'd191, COL_BLACK, 6'd39, PM_CLEAR, 8'hFF));
      issue(mk(OP_LOAD, 9'd0, 8'd191, COL_BLACK, 6'd38, PM_CLEAR, 8'h2A));
      issue(mk(OP_LOAD, 9'd0, 8'd192, COL_BLACK, 6'd63, PM_CLEAR, 8'h55));
      issue(mk(OP_READ, 9'd0, 8'd191, COL_BLACK, 6'd39, PM_CLEAR, 8'h00));
      issue(mk(OP_READ, 9'd0, 8'd255, COL_BLACK, 6'd40, PM_CLEAR, 8'h00));

      // plots: white, violet that changes nothing, orange snapping off column zero
      issue(mk(OP_PLOT, 9'd0, 8'd0, COL_WHITE, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_PLOT, 9'd1, 8'd0, COL_VIOLET, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_PLOT, 9'd0, 8'd0, COL_ORANGE, 6'd0, PM_CLEAR, 8'h00));
      // last column: green clears the palette, blue snaps left, black clears the pixel
      issue(mk(OP_PLOT, 9'd279, 8'd191, COL_GREEN, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_PLOT, 9'd279, 8'd191, COL_BLUE, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_PLOT, 9'd278, 8'd191, COL_BLACK, 6'd0, PM_CLEAR, 8'h00));
      // unknown colours, one at far out-of-range coordinates
      issue(mk(OP_PLOT, 9'd5, 8'd0, COL_SPARE_6, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_PLOT, 9'd511, 8'd255, COL_SPARE_7, 6'd0, PM_CLEAR, 8'h00));

      // queries: white between lit neighbours, orange at palette one, rejected column
      issue(mk(OP_QUERY, 9'd9, 8'd0, COL_BLACK, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_QUERY, 9'd1, 8'd0, COL_BLACK, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_QUERY, 9'd280, 8'd0, COL_BLACK, 6'd0, PM_CLEAR, 8'h00));

      // palette: set, clear with nothing to clear, toggle and the spare toggle code
      issue(mk(OP_PAL, 9'd0, 8'd0, COL_BLACK, 6'd1, PM_SET, 8'h00));
      issue(mk(OP_PAL, 9'd0, 8'd191, COL_BLACK, 6'd38, PM_CLEAR, 8'h00));
      issue(mk(OP_PAL, 9'd0, 8'd191, COL_BLACK, 6'd38, PM_TOGGLE, 8'h00));
      issue(mk(OP_PAL, 9'd0, 8'd191, COL_BLACK, 6'd38, PM_TOGGLE_ALT, 8'h00));

      // seams: matching palettes, differing palettes at the last pair, rejected column
      issue(mk(OP_SEAM, 9'd0, 8'd0, COL_BLACK, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_SEAM, 9'd0, 8'd191, COL_BLACK, 6'd38, PM_CLEAR, 8'h00));
      issue(mk(OP_SEAM, 9'd0, 8'd0, COL_BLACK, 6'd39, PM_CLEAR, 8'h00));

      issue(mk(OP_SPARE_6, 9'd0, 8'd0, COL_BLACK, 6'd0, PM_CLEAR, 8'h00));
      issue(mk(OP_SPARE_7, 9'd511, 8'd255, COL_SPARE_7, 6'd63, PM_TOGGLE_ALT, 8'hFF));

      drain();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // a stretch at full rate on both sides
         calm = (i >= 350 && i < 500);
         if (i == 250) drain();
         issue(random_cmd());
      end

      calm = 1'b0;
      drain();
      // let any stray response word show up before the verdict
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
